>>> sv/ale_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the array list engine: sizes, record layout,
// operation and status codes. No dependencies.
package ale_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 2;
    localparam int ID_W     = 32;
    localparam int PRICE_W  = 24;
    localparam int DISC_W   = 14;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_A = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_B = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [DISC_W-1:0]  discount;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

>>> sv/ale_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ale_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/array_list_engine_core.sv
`timescale 1ns / 1ps
// Array list engine top level: sequencer around one record RAM.
// Depends on ale_pkg and ale_ram.
//
// One request is taken when start is high and busy is low; its single result
// appears on status, found and count for exactly one cycle with done high, and
// must be captured then. Timing is set by the one RAM read port and the shared
// id comparator walking one entry per cycle: append finishes in the accept
// cycle, search reads entries in order until a hit or the end of the list,
// remove moves each later entry down one slot, swap reads both entries and
// writes them back crossed, and requests rejected by a status check finish
// in the accept cycle. done is registered and rises in the cycle after the
// last working cycle, and a new request may be started in that same cycle.
// The longest request is a search of a full list that misses.
module array_list_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ale_pkg::MODE_W-1:0]    mode,
    input  logic [ale_pkg::ID_W-1:0]      item_id,
    input  logic [ale_pkg::PRICE_W-1:0]   price,
    input  logic [ale_pkg::DISC_W-1:0]    discount,
    input  logic [ale_pkg::POS_W-1:0]     position_a,
    input  logic [ale_pkg::POS_W-1:0]     position_b,
    output logic                          done,
    output logic [ale_pkg::STATUS_W-1:0]  status,
    output logic                          found,
    output logic [ale_pkg::COUNT_W-1:0]   count
);

    import ale_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_SWAP_RDB,
        ST_SWAP_WA,
        ST_SWAP_WB
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]   wr_idx_reg, wr_idx_next;
    logic                pend_reg, pend_next;
    logic [ID_W-1:0]     key_reg, key_next;
    logic [ADDR_W-1:0]   pa_reg, pa_next;
    logic [ADDR_W-1:0]   pb_reg, pb_next;
    rec_t                hold_reg, hold_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    rec_t                ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    rec_t                ram_rdata;

    logic [CNT_W-1:0]    pa_ext;
    logic [CNT_W-1:0]    pb_ext;
    logic [CNT_W-1:0]    rd_idx_m1;
    logic                hit;
    logic                accept;

    ale_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign pa_ext    = CNT_W'(position_a);
    assign pb_ext    = CNT_W'(position_b);
    assign rd_idx_m1 = rd_idx_reg - 1'b1;
    // the shared comparator: id of the entry read last cycle against the key
    assign hit       = pend_reg && (ram_rdata.id == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        pend_next   = pend_reg;
        key_next    = key_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        hold_next   = hold_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next    = item_id;
                    pa_next     = ADDR_W'(position_a);
                    pb_next     = ADDR_W'(position_b);
                    pend_next   = 1'b0;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    unique case (mode)
                        MODE_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = count_reg[ADDR_W-1:0];
                                ram_wdata = '{id: item_id, price: price, discount: discount};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else if (pa_ext >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_BAD_A;
                            end
                            else
                            begin
                                rd_idx_next = pa_ext + 1'b1;
                                state_next  = ST_SHIFT;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            rd_idx_next = '0;
                            state_next  = ST_SEARCH;
                        end
                        MODE_SWAP:
                        begin
                            if (pa_ext >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_BAD_A;
                            end
                            else if (pb_ext >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_BAD_B;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(position_a);
                                state_next = ST_SWAP_RDB;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                priority if (hit)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (rd_idx_reg == count_reg)
                begin
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // write back the entry read last cycle one slot lower
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[ADDR_W-1:0];
                    wr_idx_next = rd_idx_m1[ADDR_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWAP_RDB:
            begin
                hold_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = pb_reg;
                state_next = ST_SWAP_WA;
            end
            ST_SWAP_WA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pa_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_SWAP_WB;
            end
            ST_SWAP_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pb_reg;
                ram_wdata  = hold_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        key_reg    <= key_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        hold_reg   <= hold_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign found  = found_reg;
    assign count  = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == STATUS_FULL) |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status while list has room");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> status_reg == STATUS_OK)
        else $error("found flag with error status");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy || done_reg)
        else $error("accepted item neither in progress nor answered");

endmodule

>>> tb/sv/tb_array_list_engine_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_list_engine_core: directed and random
// append, remove, search and swap items against a tracking model of the list.
// Depends on ale_pkg and the array_list_engine_core RTL.
module tb_array_list_engine_core;
    import ale_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_GAP      = 60;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [MODE_W-1:0]   op;
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    // Tracks the list contents and queues the reply each accepted item should produce.
    class list_tracker;
        rec_t        store [CAPACITY];
        int unsigned fill;
        reply_t      pending_replies [$];
        int          errors;
        int          checked;
        int          op_count [4];
        int          full_hits;

        function new();
            fill      = 0;
            errors    = 0;
            checked   = 0;
            full_hits = 0;
            foreach (op_count[i]) op_count[i] = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void note_request(logic [MODE_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [PRICE_W-1:0] pr, logic [DISC_W-1:0] dc,
                                   logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
            reply_t r;
            rec_t   tmp;
            int     i;
            r.op     = op;
            r.status = STATUS_OK;
            r.found  = 1'b0;
            op_count[op]++;
            case (op)
                MODE_APPEND:
                begin
                    if (fill >= CAPACITY)
                    begin
                        r.status = STATUS_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        store[fill] = {id, pr, dc};
                        fill++;
                    end
                end
                MODE_REMOVE:
                begin
                    if (fill == 0)
                        r.status = STATUS_EMPTY;
                    else if (pa >= fill)
                        r.status = STATUS_BAD_A;
                    else
                    begin
                        // shift later records down over the removed one
                        for (i = pa; i + 1 < fill; i++)
                            store[i] = store[i + 1];
                        fill--;
                    end
                end
                MODE_SEARCH:
                begin
                    for (i = 0; i < fill; i++)
                        if (store[i].id == id)
                            r.found = 1'b1;
                end
                default:
                begin
                    if (pa >= fill)
                        r.status = STATUS_BAD_A;
                    else if (pb >= fill)
                        r.status = STATUS_BAD_B;
                    else
                    begin
                        tmp       = store[pa];
                        store[pa] = store[pb];
                        store[pb] = tmp;
                    end
                end
            endcase
            r.count = COUNT_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic f, logic [COUNT_W-1:0] cnt);
            reply_t r;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result with no item waiting: status %0d found %0d count %0d",
                         $time, st, f, cnt);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            checked++;
            if (st !== r.status)
            begin
                $display("%0t: status mismatch (mode %0d): expected %0d actual %0d",
                         $time, r.op, r.status, st);
                errors++;
            end
            if (f !== r.found)
            begin
                $display("%0t: found mismatch (mode %0d): expected %0d actual %0d",
                         $time, r.op, r.found, f);
                errors++;
            end
            if (cnt !== r.count)
            begin
                $display("%0t: count mismatch (mode %0d): expected %0d actual %0d",
                         $time, r.op, r.count, cnt);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (pending_replies.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived: expected 0 actual %0d",
                         $time, pending_replies.size(), pending_replies.size());
                errors++;
            end
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [MODE_W-1:0]   mode       = MODE_APPEND;
    logic [ID_W-1:0]     item_id    = '0;
    logic [PRICE_W-1:0]  price      = '0;
    logic [DISC_W-1:0]   discount   = '0;
    logic [POS_W-1:0]    position_a = '0;
    logic [POS_W-1:0]    position_b = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;

    int          cycle_count = 0;
    list_tracker tracker;

    array_list_engine_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .item_id    (item_id),
        .price      (price),
        .discount   (discount),
        .position_a (position_a),
        .position_b (position_b),
        .done       (done),
        .status     (status),
        .found      (found),
        .count      (count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            tracker.check_result(status, found, count);
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // Present one item, hold it until accepted, then optionally drop start for a gap.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [PRICE_W-1:0] pr, input logic [DISC_W-1:0] dc,
                             input logic [POS_W-1:0] pa, input logic [POS_W-1:0] pb,
                             input int idle_pct);
        int gap;
        mode       <= op;
        item_id    <= id;
        price      <= pr;
        discount   <= dc;
        position_a <= pa;
        position_b <= pb;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_request(op, id, pr, dc, pa, pb);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        if (tracker.fill > 0 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(tracker.fill - 1));
        return POS_W'($urandom_range(15));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (tracker.fill > 0 && r < 40)
            return tracker.store[$urandom_range(tracker.fill - 1)].id;
        if (r < 45)
            return 32'h8000_0000;
        if (r < 50)
            return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic run_directed();
        int i;
        send_item(MODE_SEARCH, 32'h0, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_REMOVE, 32'h0, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_SWAP, 32'h0, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_APPEND, 32'h8000_0000, 24'hFF_FFFF, 14'd10000, 4'd0, 4'd0, 0);
        send_item(MODE_APPEND, 32'h7FFF_FFFF, 24'h0, 14'd0, 4'd15, 4'd15, 0);
        send_item(MODE_SEARCH, 32'h8000_0000, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_SEARCH, 32'hFFFF_FFFF, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_SWAP, 32'h0, '0, '0, 4'd0, 4'd15, 0);
        send_item(MODE_SWAP, 32'h0, '0, '0, 4'd15, 4'd0, 0);
        send_item(MODE_SWAP, 32'h0, '0, '0, 4'd1, 4'd0, 0);
        send_item(MODE_REMOVE, 32'h0, '0, '0, 4'd2, 4'd0, 0);
        // fill to capacity, then push one more
        for (i = 0; i < CAPACITY - 2; i++)
            send_item(MODE_APPEND, $urandom, PRICE_W'($urandom),
                      DISC_W'($urandom_range(10000)), 4'd0, 4'd0, 0);
        send_item(MODE_APPEND, 32'h5A5A_5A5A, 24'h00_0001, 14'd1, 4'd0, 4'd0, 0);
        send_item(MODE_SEARCH, 32'h7FFF_FFFF, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_REMOVE, 32'h0, '0, '0, 4'd15, 4'd0, 0);
        send_item(MODE_REMOVE, 32'h0, '0, '0, 4'd0, 4'd0, 0);
        send_item(MODE_SEARCH, 32'h8000_0000, '0, '0, 4'd0, 4'd0, 0);
    endtask

    // Random items with a fill trend that sweeps the list between empty and full.
    task automatic run_random(input int n, input int idle_pct);
        int                 k;
        int                 r;
        bit                 rising;
        logic [MODE_W-1:0]  op;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] pr;
        logic [DISC_W-1:0]  dc;
        rising = 1'b1;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                rising = ~rising;
            if (tracker.fill == CAPACITY && $urandom_range(9) < 3)
                rising = 1'b0;
            if (tracker.fill == 0 && $urandom_range(9) < 3)
                rising = 1'b1;
            r = $urandom_range(99);
            if (rising)
                op = (r < 50) ? MODE_APPEND : (r < 62) ? MODE_REMOVE :
                     (r < 82) ? MODE_SEARCH : MODE_SWAP;
            else
                op = (r < 12) ? MODE_APPEND : (r < 55) ? MODE_REMOVE :
                     (r < 78) ? MODE_SEARCH : MODE_SWAP;
            id = (op == MODE_SEARCH || $urandom_range(99) < 20) ? pick_id() : $urandom;
            r  = $urandom_range(99);
            pr = (r < 5) ? 24'h0 : (r < 10) ? 24'hFF_FFFF : PRICE_W'($urandom);
            r  = $urandom_range(99);
            dc = (r < 5) ? 14'd0 : (r < 10) ? 14'd10000 : DISC_W'($urandom_range(10000));
            send_item(op, id, pr, dc, pick_pos(), pick_pos(), idle_pct);
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random(600, 0);
        run_random(600, 88);
        run_random(550, 20);
        start <= 1'b0;
        while (tracker.pending_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.report_leftover();
        $display("Covered %0d append, %0d remove, %0d search, %0d swap items; %0d full appends.",
                 tracker.op_count[MODE_APPEND], tracker.op_count[MODE_REMOVE],
                 tracker.op_count[MODE_SEARCH], tracker.op_count[MODE_SWAP], tracker.full_hits);
        $display("Checked %0d results over back-to-back, heavy-gap and light-gap phases.",
                 tracker.checked);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
